// ===== design/stdp_pair_trace_weight_update_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the pair-trace STDP engine
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef STDP_PAIR_TRACE_WEIGHT_UPDATE_DEFINES_SVH
`define STDP_PAIR_TRACE_WEIGHT_UPDATE_DEFINES_SVH

// same-cycle implication
`define STDP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define STDP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/stdp_ptwu_pkg.sv =====
// ---------------------------------------------------------------------------
// stdp_ptwu_pkg
// Field widths and register codes of the pair-trace STDP engine.
// ---------------------------------------------------------------------------
package stdp_ptwu_pkg;

    localparam int TRACE_W   = 20;   // Q8.12 trace
    localparam int GAIN_W    = 16;   // gains, decays, increment
    localparam int WEIGHT_W  = 24;   // signed Q11.12
    localparam int LIMIT_W   = 23;   // weight clamps
    localparam int IDX_W     = 8;
    localparam int CFG_IDX_W = 3;
    localparam int MOVED_W   = WEIGHT_W + 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLED,
        CFG_A_PLUS,
        CFG_A_MINUS,
        CFG_PRE_FACTOR,
        CFG_POST_FACTOR,
        CFG_TRACE_INCREMENT,
        CFG_WEIGHT_MIN,
        CFG_WEIGHT_MAX
    } cfg_index_t;

    typedef enum logic [0:0] {
        OP_SYNAPSE,
        OP_NEURON
    } opcode_t;

endpackage

// ===== design/stdp_pair_trace_weight_update.sv =====
// result_valid rises after the decay, gain, sum and clamp states; the clamp
//   state waits while an earlier result is still held. Items are taken one at
//   a time through the read / decay / gain / sum / clamp sequence.
// A waiting result does not block the next input transfer.
// Reset: control and configuration registers return to defaults, then a
//   clearing pass zeroes both trace memories with item_ready held low.
// ---------------------------------------------------------------------------
// stdp_pair_trace_weight_update
// Pair-based STDP weight update with per-neuron pre/post traces in memory.
// ---------------------------------------------------------------------------
module stdp_pair_trace_weight_update #(
    parameter int NEURONS = 256
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        item_valid,
    output logic                                        item_ready,
    input  logic                                        opcode,
    input  logic [stdp_ptwu_pkg::IDX_W-1:0]             source_index,
    input  logic [stdp_ptwu_pkg::IDX_W-1:0]             target_index,
    input  logic signed [stdp_ptwu_pkg::WEIGHT_W-1:0]   weight,
    input  logic                                        source_excitatory,
    input  logic                                        source_spiked,
    input  logic                                        target_spiked,
    output logic                                        result_valid,
    input  logic                                        result_ready,
    output logic signed [stdp_ptwu_pkg::WEIGHT_W-1:0]   updated_weight,
    output logic                                        clamped_low,
    output logic                                        clamped_high,
    output logic                                        weight_changed,
    output logic                                        depressed,
    output logic                                        potentiated,
    output logic                                        trace_saturated,
    input  logic                                        cfg_valid,
    output logic                                        cfg_ready,
    input  logic [stdp_ptwu_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [stdp_ptwu_pkg::LIMIT_W-1:0]           cfg_data
);

    import stdp_ptwu_pkg::*;

    localparam int AW     = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam int XW     = (AW > IDX_W) ? AW : IDX_W;
    localparam int PROD_W = TRACE_W + GAIN_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECAY,
        S_GAIN,
        S_SUM,
        S_CLAMP
    } state_t;

    // configuration
    logic               enabled_reg;
    logic [GAIN_W-1:0]  a_plus_reg;
    logic [GAIN_W-1:0]  a_minus_reg;
    logic [GAIN_W-1:0]  pre_factor_reg;
    logic [GAIN_W-1:0]  post_factor_reg;
    logic [GAIN_W-1:0]  trace_inc_reg;
    logic [LIMIT_W-1:0] weight_min_reg;
    logic [LIMIT_W-1:0] weight_max_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg     <= 1'b0;
            a_plus_reg      <= GAIN_W'(4096);
            a_minus_reg     <= GAIN_W'(4301);
            pre_factor_reg  <= GAIN_W'(62339);
            post_factor_reg <= GAIN_W'(62339);
            trace_inc_reg   <= GAIN_W'(4096);
            weight_min_reg  <= '0;
            weight_max_reg  <= LIMIT_W'(819200);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_ENABLED:         enabled_reg     <= cfg_data[0];
                CFG_A_PLUS:          a_plus_reg      <= cfg_data[GAIN_W-1:0];
                CFG_A_MINUS:         a_minus_reg     <= cfg_data[GAIN_W-1:0];
                CFG_PRE_FACTOR:      pre_factor_reg  <= cfg_data[GAIN_W-1:0];
                CFG_POST_FACTOR:     post_factor_reg <= cfg_data[GAIN_W-1:0];
                CFG_TRACE_INCREMENT: trace_inc_reg   <= cfg_data[GAIN_W-1:0];
                CFG_WEIGHT_MIN:      weight_min_reg  <= cfg_data;
                CFG_WEIGHT_MAX:      weight_max_reg  <= cfg_data;
                default:             ;
            endcase
        end
    end

    // control and result registers
    state_t             state_reg;
    logic               clr_active_reg;
    logic [AW-1:0]      clr_addr_reg;
    logic               result_valid_reg;
    logic [WEIGHT_W-1:0] out_weight_reg;
    logic               out_low_reg;
    logic               out_high_reg;
    logic               out_changed_reg;
    logic               out_dep_reg;
    logic               out_pot_reg;
    logic               out_sat_reg;

    logic item_fire;
    assign item_ready = (state_reg == S_IDLE) && !clr_active_reg;
    assign item_fire  = item_valid && item_ready;

    // address decode at the input transfer
    logic [IDX_W-1:0] post_idx;
    logic [XW-1:0]    src_wide;
    logic [XW-1:0]    post_wide;
    logic [AW-1:0]    src_addr;
    logic [AW-1:0]    post_addr;
    logic             src_ok;
    logic             post_ok;

    assign post_idx  = (opcode == OP_NEURON) ? source_index : target_index;
    assign src_wide  = XW'(source_index);
    assign post_wide = XW'(post_idx);
    assign src_addr  = src_wide[AW-1:0];
    assign post_addr = post_wide[AW-1:0];
    assign src_ok    = int'(source_index) < NEURONS;
    assign post_ok   = int'(post_idx) < NEURONS;

    // latched item
    logic                op_reg;
    logic [AW-1:0]       src_addr_reg;
    logic [WEIGHT_W-1:0] w_reg;
    logic                excit_reg;
    logic                sspk_reg;
    logic                tspk_reg;
    logic                pre_ok_reg;
    logic                post_ok_reg;

    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            op_reg       <= opcode;
            src_addr_reg <= src_addr;
            w_reg        <= weight;
            excit_reg    <= source_excitatory;
            sspk_reg     <= source_spiked;
            tspk_reg     <= target_spiked;
            pre_ok_reg   <= src_ok;
            post_ok_reg  <= post_ok;
        end
    end

    // trace memories, one shared write address
    logic [TRACE_W-1:0] pre_mem  [NEURONS];
    logic [TRACE_W-1:0] post_mem [NEURONS];
    logic [TRACE_W-1:0] pre_rd_reg;
    logic [TRACE_W-1:0] post_rd_reg;

    logic               neuron_we;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [TRACE_W-1:0] pre_wdata;
    logic [TRACE_W-1:0] post_wdata;
    logic [TRACE_W:0]   pre_sum;
    logic [TRACE_W:0]   post_sum;

    assign mem_we    = clr_active_reg || neuron_we;
    assign mem_waddr = clr_active_reg ? clr_addr_reg : src_addr_reg;
    assign pre_wdata  = clr_active_reg ? '0 :
                        (pre_sum[TRACE_W] ? '1 : pre_sum[TRACE_W-1:0]);
    assign post_wdata = clr_active_reg ? '0 :
                        (post_sum[TRACE_W] ? '1 : post_sum[TRACE_W-1:0]);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            pre_mem[mem_waddr] <= pre_wdata;
        if (item_fire)
            pre_rd_reg <= pre_mem[src_addr];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            post_mem[mem_waddr] <= post_wdata;
        if (item_fire)
            post_rd_reg <= post_mem[post_addr];
    end

    // decay stage
    logic [PROD_W-1:0]  pre_prod;
    logic [PROD_W-1:0]  post_prod;
    logic [TRACE_W-1:0] pre_dec_reg;
    logic [TRACE_W-1:0] post_dec_reg;

    assign pre_prod  = PROD_W'(pre_rd_reg) * PROD_W'(pre_factor_reg);
    assign post_prod = PROD_W'(post_rd_reg) * PROD_W'(post_factor_reg);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DECAY)
        begin
            // out-of-range neurons read as zero
            pre_dec_reg  <= pre_ok_reg ? pre_prod[PROD_W-1:16] : '0;
            post_dec_reg <= post_ok_reg ? post_prod[PROD_W-1:16] : '0;
        end
    end

    // gain stage; neuron items write back here
    logic [PROD_W-1:0]   pot_prod;
    logic [PROD_W-1:0]   dep_prod;
    logic [GAIN_W-1:0]   inc;
    logic [WEIGHT_W-1:0] pot_reg;
    logic [WEIGHT_W-1:0] dep_reg;
    logic                sat_reg;

    assign pot_prod  = PROD_W'(a_plus_reg) * PROD_W'(pre_dec_reg);
    assign dep_prod  = PROD_W'(a_minus_reg) * PROD_W'(post_dec_reg);
    assign inc       = sspk_reg ? trace_inc_reg : '0;
    assign pre_sum   = (TRACE_W+1)'(pre_dec_reg) + (TRACE_W+1)'(inc);
    assign post_sum  = (TRACE_W+1)'(post_dec_reg) + (TRACE_W+1)'(inc);
    assign neuron_we = (state_reg == S_GAIN) && (op_reg == OP_NEURON)
                       && enabled_reg && pre_ok_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_GAIN)
        begin
            pot_reg <= tspk_reg ? pot_prod[PROD_W-1:12] : '0;
            dep_reg <= sspk_reg ? dep_prod[PROD_W-1:12] : '0;
            sat_reg <= neuron_we && (pre_sum[TRACE_W] || post_sum[TRACE_W]);
        end
    end

    // sum stage
    logic signed [MOVED_W-1:0] w_ext;
    logic signed [MOVED_W-1:0] moved;
    logic signed [MOVED_W-1:0] moved_reg;
    logic                      elig_reg;
    logic                      sum_nz_reg;
    logic                      dep_nz_reg;
    logic                      pot_nz_reg;

    assign w_ext = MOVED_W'($signed(w_reg));
    assign moved = w_ext + $signed(MOVED_W'(pot_reg)) - $signed(MOVED_W'(dep_reg));

    always_ff @(posedge clk)
    begin
        if (state_reg == S_SUM)
        begin
            moved_reg  <= moved;
            elig_reg   <= (op_reg == OP_SYNAPSE) && enabled_reg && excit_reg
                          && !w_reg[WEIGHT_W-1];
            sum_nz_reg <= pot_reg != dep_reg;
            dep_nz_reg <= dep_reg != '0;
            pot_nz_reg <= pot_reg != '0;
        end
    end

    // clamp stage
    logic signed [MOVED_W-1:0] min_ext;
    logic signed [MOVED_W-1:0] max_ext;
    logic signed [MOVED_W-1:0] final_w;
    logic                      low_next;
    logic                      high_next;
    logic                      result_load;

    assign min_ext = $signed(MOVED_W'(weight_min_reg));
    assign max_ext = $signed(MOVED_W'(weight_max_reg));

    always_comb
    begin
        final_w   = w_ext;
        low_next  = 1'b0;
        high_next = 1'b0;
        if (elig_reg && sum_nz_reg)
        begin
            if (moved_reg < min_ext)
            begin
                final_w  = min_ext;
                low_next = 1'b1;
            end
            else if (moved_reg > max_ext)
            begin
                final_w   = max_ext;
                high_next = 1'b1;
            end
            else
                final_w = moved_reg;
        end
    end

    assign result_load = (state_reg == S_CLAMP) && (!result_valid_reg || result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            clr_active_reg   <= 1'b1;
            clr_addr_reg     <= '0;
            result_valid_reg <= 1'b0;
            out_weight_reg   <= '0;
            out_low_reg      <= 1'b0;
            out_high_reg     <= 1'b0;
            out_changed_reg  <= 1'b0;
            out_dep_reg      <= 1'b0;
            out_pot_reg      <= 1'b0;
            out_sat_reg      <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(NEURONS - 1))
                    clr_active_reg <= 1'b0;
            end

            if (result_load)
            begin
                result_valid_reg <= 1'b1;
                if (op_reg == OP_NEURON)
                begin
                    out_weight_reg  <= '0;
                    out_low_reg     <= 1'b0;
                    out_high_reg    <= 1'b0;
                    out_changed_reg <= 1'b0;
                    out_dep_reg     <= 1'b0;
                    out_pot_reg     <= 1'b0;
                    out_sat_reg     <= sat_reg;
                end
                else
                begin
                    out_weight_reg  <= final_w[WEIGHT_W-1:0];
                    out_low_reg     <= low_next;
                    out_high_reg    <= high_next;
                    out_changed_reg <= final_w != w_ext;
                    out_dep_reg     <= elig_reg && dep_nz_reg;
                    out_pot_reg     <= elig_reg && pot_nz_reg;
                    out_sat_reg     <= 1'b0;
                end
            end
            else if (result_ready)
                result_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:  if (item_fire) state_reg <= S_DECAY;
                S_DECAY: state_reg <= S_GAIN;
                S_GAIN:  state_reg <= S_SUM;
                S_SUM:   state_reg <= S_CLAMP;
                S_CLAMP: if (result_load) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign result_valid    = result_valid_reg;
    assign updated_weight  = $signed(out_weight_reg);
    assign clamped_low     = out_low_reg;
    assign clamped_high    = out_high_reg;
    assign weight_changed  = out_changed_reg;
    assign depressed       = out_dep_reg;
    assign potentiated     = out_pot_reg;
    assign trace_saturated = out_sat_reg;

endmodule

// ===== design/stdp_ptwu_checker.sv =====
// ---------------------------------------------------------------------------
// stdp_ptwu_checker
// Port-level checks of the pair-trace STDP engine, bound to the top level.
// ---------------------------------------------------------------------------
`include "stdp_pair_trace_weight_update_defines.svh"

module stdp_ptwu_checker (
    input logic                                       clk,
    input logic                                       rst_n,
    input logic                                       item_valid,
    input logic                                       item_ready,
    input logic                                       result_valid,
    input logic                                       result_ready,
    input logic signed [stdp_ptwu_pkg::WEIGHT_W-1:0]  updated_weight,
    input logic                                       clamped_low,
    input logic                                       clamped_high,
    input logic                                       weight_changed,
    input logic                                       depressed,
    input logic                                       potentiated,
    input logic                                       trace_saturated
);

    import stdp_ptwu_pkg::*;

    logic signed [WEIGHT_W-1:0] zero_w;
    assign zero_w = '0;

    // stalled result holds
    `STDP_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
        result_valid && $stable(updated_weight), "result changed while stalled")

    // one item in flight at a time
    `STDP_ASSERT_NEXT(a_one_in_flight, item_valid && item_ready, !item_ready,
        "input taken twice in a row")

    `STDP_ASSERT_NOW(a_clamp_exclusive, result_valid, !(clamped_low && clamped_high),
        "both clamp flags set")

    // a saturating neuron result carries no weight information
    `STDP_ASSERT_NOW(a_neuron_result, result_valid && trace_saturated,
        updated_weight == zero_w && !weight_changed && !depressed && !potentiated
        && !clamped_low && !clamped_high, "neuron result has weight flags")

endmodule

bind stdp_pair_trace_weight_update stdp_ptwu_checker u_stdp_ptwu_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pair-trace STDP weight update testbench
// Sends synapse and neuron items to the engine under several register
// settings. A scoreboard keeps its own copy of the pre and post trace memories
// and predicts every result, which is then compared field by field. Both
// handshakes see random stall bursts, one long receiver hold-off and drains
// between settings.
// ----------------------------------------------------------------------------
module testbench;
    import stdp_ptwu_pkg::*;

    localparam int N_NEURONS = 256;
    localparam logic [TRACE_W-1:0] TRACE_FULL = '1;

    typedef struct packed {
        opcode_t                    op;
        logic [IDX_W-1:0]           src;
        logic [IDX_W-1:0]           tgt;
        logic signed [WEIGHT_W-1:0] w;
        logic                       excit;
        logic                       src_spk;
        logic                       tgt_spk;
    } stdp_item_t;

    typedef struct packed {
        logic signed [WEIGHT_W-1:0] updated_weight;
        logic                       clamped_low;
        logic                       clamped_high;
        logic                       weight_changed;
        logic                       depressed;
        logic                       potentiated;
        logic                       trace_saturated;
    } stdp_result_t;

    class weight_update_scoreboard;
        logic [TRACE_W-1:0] pre_copy [N_NEURONS];
        logic [TRACE_W-1:0] post_copy [N_NEURONS];
        logic               learn_on;
        logic [GAIN_W-1:0]  a_plus;
        logic [GAIN_W-1:0]  a_minus;
        logic [GAIN_W-1:0]  pre_factor;
        logic [GAIN_W-1:0]  post_factor;
        logic [GAIN_W-1:0]  trace_inc;
        logic [LIMIT_W-1:0] w_min;
        logic [LIMIT_W-1:0] w_max;
        stdp_result_t       due_results [$];
        int                 errors;

        function new();
            foreach (pre_copy[i])
            begin
                pre_copy[i]  = '0;
                post_copy[i] = '0;
            end
            learn_on    = 1'b0;
            a_plus      = 16'd4096;
            a_minus     = 16'd4301;
            pre_factor  = 16'd62339;
            post_factor = 16'd62339;
            trace_inc   = 16'd4096;
            w_min       = 23'd0;
            w_max       = 23'd819200;
            errors      = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [LIMIT_W-1:0] data);
            case (idx)
                CFG_ENABLED:         learn_on    = data[0];
                CFG_A_PLUS:          a_plus      = data[GAIN_W-1:0];
                CFG_A_MINUS:         a_minus     = data[GAIN_W-1:0];
                CFG_PRE_FACTOR:      pre_factor  = data[GAIN_W-1:0];
                CFG_POST_FACTOR:     post_factor = data[GAIN_W-1:0];
                CFG_TRACE_INCREMENT: trace_inc   = data[GAIN_W-1:0];
                CFG_WEIGHT_MIN:      w_min       = data;
                CFG_WEIGHT_MAX:      w_max       = data;
                default:             ;
            endcase
        endfunction

        function logic [TRACE_W-1:0] decayed(logic [TRACE_W-1:0] tr, logic [GAIN_W-1:0] f);
            logic [TRACE_W+GAIN_W-1:0] prod;
            prod = tr * f;
            return prod[TRACE_W+GAIN_W-1:GAIN_W];
        endfunction

        function longint gain_term(logic [GAIN_W-1:0] g, logic [TRACE_W-1:0] tr);
            logic [TRACE_W+GAIN_W-1:0] prod;
            prod = g * tr;
            return longint'(prod[TRACE_W+GAIN_W-1:12]);
        endfunction

        // Predicts the result of an accepted item and commits trace updates.
        function void log_item(stdp_item_t it);
            stdp_result_t       r;
            logic [TRACE_W:0]   p;
            logic [TRACE_W:0]   q;
            logic [TRACE_W-1:0] pre;
            logic [TRACE_W-1:0] post;
            longint             w0;
            longint             nw;
            longint             dep;
            longint             pot;
            r  = '0;
            w0 = longint'($signed(it.w));
            nw = w0;
            if (it.op == OP_NEURON)
            begin
                if (learn_on && it.src < N_NEURONS)
                begin
                    p = decayed(pre_copy[it.src], pre_factor)
                        + ({GAIN_W{it.src_spk}} & trace_inc);
                    q = decayed(post_copy[it.src], post_factor)
                        + ({GAIN_W{it.src_spk}} & trace_inc);
                    if (p > TRACE_FULL)
                    begin
                        p = TRACE_FULL;
                        r.trace_saturated = 1'b1;
                    end
                    if (q > TRACE_FULL)
                    begin
                        q = TRACE_FULL;
                        r.trace_saturated = 1'b1;
                    end
                    pre_copy[it.src]  = p[TRACE_W-1:0];
                    post_copy[it.src] = q[TRACE_W-1:0];
                end
            end
            else
            begin
                if (learn_on && it.excit && w0 >= 0)
                begin
                    pre  = (it.src < N_NEURONS) ? decayed(pre_copy[it.src], pre_factor) : '0;
                    post = (it.tgt < N_NEURONS) ? decayed(post_copy[it.tgt], post_factor) : '0;
                    dep  = it.src_spk ? gain_term(a_minus, post) : 0;
                    pot  = it.tgt_spk ? gain_term(a_plus, pre) : 0;
                    r.depressed   = (dep != 0);
                    r.potentiated = (pot != 0);
                    // zero net change leaves the weight alone, no clamp
                    if (pot != dep)
                    begin
                        nw = w0 + pot - dep;
                        if (nw < longint'(w_min))
                        begin
                            nw = longint'(w_min);
                            r.clamped_low = 1'b1;
                        end
                        else if (nw > longint'(w_max))
                        begin
                            nw = longint'(w_max);
                            r.clamped_high = 1'b1;
                        end
                    end
                end
                r.updated_weight = nw[WEIGHT_W-1:0];
                r.weight_changed = (nw != w0);
            end
            due_results.push_back(r);
        endfunction

        task flag_mismatch(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task compare(string field, longint got, longint want);
            if (got != want)
            begin
                flag_mismatch($sformatf("%s got 0x%0h, want 0x%0h", field, got, want));
            end
        endtask

        task check_result(stdp_result_t got);
            stdp_result_t want;
            if (due_results.size() == 0)
            begin
                flag_mismatch("result transfer with nothing outstanding");
                return;
            end
            want = due_results.pop_front();
            compare("updated_weight", got.updated_weight, want.updated_weight);
            compare("clamped_low", got.clamped_low, want.clamped_low);
            compare("clamped_high", got.clamped_high, want.clamped_high);
            compare("weight_changed", got.weight_changed, want.weight_changed);
            compare("depressed", got.depressed, want.depressed);
            compare("potentiated", got.potentiated, want.potentiated);
            compare("trace_saturated", got.trace_saturated, want.trace_saturated);
        endtask
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       item_valid;
    logic                       item_ready;
    logic                       opcode;
    logic [IDX_W-1:0]           source_index;
    logic [IDX_W-1:0]           target_index;
    logic signed [WEIGHT_W-1:0] weight;
    logic                       source_excitatory;
    logic                       source_spiked;
    logic                       target_spiked;
    logic                       result_valid;
    logic                       result_ready;
    logic signed [WEIGHT_W-1:0] updated_weight;
    logic                       clamped_low;
    logic                       clamped_high;
    logic                       weight_changed;
    logic                       depressed;
    logic                       potentiated;
    logic                       trace_saturated;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [LIMIT_W-1:0]         cfg_data;

    weight_update_scoreboard weights_sb;
    bit tx_gaps_on;
    bit rx_stalls_on;
    int hold_span;      // nonzero asks the result side for one long hold-off

    stdp_pair_trace_weight_update #(
        .NEURONS(N_NEURONS)
    ) u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_valid        (item_valid),
        .item_ready        (item_ready),
        .opcode            (opcode),
        .source_index      (source_index),
        .target_index      (target_index),
        .weight            (weight),
        .source_excitatory (source_excitatory),
        .source_spiked     (source_spiked),
        .target_spiked     (target_spiked),
        .result_valid      (result_valid),
        .result_ready      (result_ready),
        .updated_weight    (updated_weight),
        .clamped_low       (clamped_low),
        .clamped_high      (clamped_high),
        .weight_changed    (weight_changed),
        .depressed         (depressed),
        .potentiated       (potentiated),
        .trace_saturated   (trace_saturated),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin : watchdog
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    // Result sink: random stall bursts, plus one long hold counted here.
    initial
    begin : result_sink
        int n;
        result_ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_span > 0)
            begin
                n = hold_span;
                result_ready <= 1'b0;
                repeat (n) @(negedge clk);
                hold_span = 0;
                result_ready <= 1'b1;
            end
            else if (rx_stalls_on && $urandom_range(0, 7) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
                result_ready <= 1'b1;
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        stdp_result_t seen;
        stdp_item_t   took;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                seen.updated_weight  = updated_weight;
                seen.clamped_low     = clamped_low;
                seen.clamped_high    = clamped_high;
                seen.weight_changed  = weight_changed;
                seen.depressed       = depressed;
                seen.potentiated     = potentiated;
                seen.trace_saturated = trace_saturated;
                weights_sb.check_result(seen);
            end
            if (cfg_valid && cfg_ready)
            begin
                weights_sb.set_reg(cfg_index_t'(cfg_index), cfg_data);
            end
            if (item_valid && item_ready)
            begin
                took.op      = opcode_t'(opcode);
                took.src     = source_index;
                took.tgt     = target_index;
                took.w       = weight;
                took.excit   = source_excitatory;
                took.src_spk = source_spiked;
                took.tgt_spk = target_spiked;
                weights_sb.log_item(took);
            end
        end
    end

    function automatic stdp_item_t make_item(opcode_t op, int src, int tgt,
                                             logic [WEIGHT_W-1:0] w, bit ex, bit ss, bit ts);
        stdp_item_t it;
        it.op      = op;
        it.src     = src[IDX_W-1:0];
        it.tgt     = tgt[IDX_W-1:0];
        it.w       = w;
        it.excit   = ex;
        it.src_spk = ss;
        it.tgt_spk = ts;
        return it;
    endfunction

    function automatic bit chance(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        logic [WEIGHT_W-1:0] w;
        case ($urandom_range(0, 7))
            0:       w = WEIGHT_W'($urandom);
            1:       w = {1'b1, 23'($urandom)};
            2:       w = WEIGHT_W'({1'b0, weights_sb.w_min} + $urandom_range(0, 8192));
            3:       w = WEIGHT_W'({1'b0, weights_sb.w_max} - $urandom_range(0, 8192));
            6:       w = '0;
            7:       w = 24'h7FFFFF;
            default: w = WEIGHT_W'($urandom_range(0, 1 << 20));
        endcase
        return w;
    endfunction

    task automatic send_item(input stdp_item_t it);
        if (tx_gaps_on && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        item_valid        <= 1'b1;
        opcode            <= it.op;
        source_index      <= it.src;
        target_index      <= it.tgt;
        weight            <= it.w;
        source_excitatory <= it.excit;
        source_spiked     <= it.src_spk;
        target_spiked     <= it.tgt_spk;
        do @(posedge clk); while (!item_ready);
        @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [LIMIT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    // Sender pause until every outstanding result has been taken.
    task automatic drain();
        item_valid <= 1'b0;
        do @(negedge clk); while (weights_sb.due_results.size() != 0);
    endtask

    task automatic apply_settings(input bit en, input int ap, input int am, input int pd,
                                  input int qd, input int inc, input int wmin, input int wmax);
        write_reg(CFG_ENABLED, LIMIT_W'(en));
        write_reg(CFG_A_PLUS, LIMIT_W'(ap));
        write_reg(CFG_A_MINUS, LIMIT_W'(am));
        write_reg(CFG_PRE_FACTOR, LIMIT_W'(pd));
        write_reg(CFG_POST_FACTOR, LIMIT_W'(qd));
        write_reg(CFG_TRACE_INCREMENT, LIMIT_W'(inc));
        write_reg(CFG_WEIGHT_MIN, LIMIT_W'(wmin));
        write_reg(CFG_WEIGHT_MAX, LIMIT_W'(wmax));
        cfg_valid <= 1'b0;
    endtask

    function automatic int pick_gain();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 65535;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic int pick_decay();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return 65535;
            default: return $urandom_range(40000, 65535);
        endcase
    endfunction

    task automatic apply_random_settings(input bit en, input bit inverted_limits);
        int inc;
        int lo;
        int hi;
        case ($urandom_range(0, 3))
            0:       inc = 1;
            1:       inc = 65535;
            default: inc = $urandom_range(1, 65535);
        endcase
        lo = $urandom_range(0, 1 << 20);
        hi = lo + $urandom_range(1, 1 << 21);
        if (hi > 8388607)
        begin
            hi = 8388607;
        end
        if (inverted_limits)
        begin
            hi = $urandom_range(1, lo);
            lo = lo + 4096;
        end
        apply_settings(en, pick_gain(), pick_gain(), pick_decay(), pick_decay(), inc, lo, hi);
    endtask

    // Simulation steps over a small neuron pool: synapse items, then the
    // neuron items that close the step. Some items are pure noise.
    task automatic run_phase(input int n_items, input int spike_pct, input bit stalls,
                             input bit squeeze);
        int         pool [$];
        int         sent;
        int         nsyn;
        bit         squeezed;
        stdp_item_t it;
        tx_gaps_on   = stalls && !squeeze;
        rx_stalls_on = stalls;
        squeezed     = 1'b0;
        repeat ($urandom_range(3, 12)) pool.push_back($urandom_range(0, N_NEURONS - 1));
        if (chance(50))
        begin
            pool.push_back(0);
        end
        if (chance(50))
        begin
            pool.push_back(N_NEURONS - 1);
        end
        sent = 0;
        while (sent < n_items)
        begin
            if (squeeze && !squeezed && sent >= 30)
            begin
                hold_span = 150;
                squeezed  = 1'b1;
            end
            nsyn = $urandom_range(0, 6);
            repeat (nsyn)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    it = make_item(opcode_t'($urandom_range(0, 1)), $urandom, $urandom,
                                   WEIGHT_W'($urandom), 1'($urandom), 1'($urandom),
                                   1'($urandom));
                end
                else
                begin
                    it = make_item(OP_SYNAPSE, pool[$urandom_range(0, pool.size() - 1)],
                                   pool[$urandom_range(0, pool.size() - 1)], pick_weight(),
                                   $urandom_range(0, 7) != 0, chance(spike_pct), chance(spike_pct));
                end
                send_item(it);
                sent++;
            end
            foreach (pool[j])
            begin
                if ($urandom_range(0, 7) != 0)
                begin
                    send_item(make_item(OP_NEURON, pool[j], $urandom, WEIGHT_W'($urandom),
                                        1'($urandom), chance(spike_pct), 1'($urandom)));
                    sent++;
                end
            end
        end
    endtask

    initial
    begin : stimulus
        rst_n             <= 1'b0;
        item_valid        <= 1'b0;
        opcode            <= OP_SYNAPSE;
        source_index      <= '0;
        target_index      <= '0;
        weight            <= '0;
        source_excitatory <= 1'b0;
        source_spiked     <= 1'b0;
        target_spiked     <= 1'b0;
        cfg_valid         <= 1'b0;
        cfg_index         <= CFG_ENABLED;
        cfg_data          <= '0;
        tx_gaps_on        = 1'b0;
        rx_stalls_on      = 1'b0;
        hold_span         = 0;
        weights_sb        = new();
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // learning off after reset: pass-through, traces untouched
        send_item(make_item(OP_SYNAPSE, 0, 255, 24'h7FFFFF, 1, 1, 1));
        send_item(make_item(OP_NEURON, 0, 0, 0, 0, 1, 0));
        drain();
        apply_settings(1, 65535, 65535, 65535, 65535, 65535, 0, 8388607);
        send_item(make_item(OP_NEURON, 0, 0, 0, 0, 1, 0));
        send_item(make_item(OP_NEURON, 255, 0, 0, 0, 1, 0));
        send_item(make_item(OP_SYNAPSE, 0, 255, 0, 1, 0, 1));             // potentiation
        send_item(make_item(OP_SYNAPSE, 0, 255, 100, 1, 1, 0));           // depression, floor
        send_item(make_item(OP_SYNAPSE, 0, 255, 5000, 1, 1, 1));          // terms cancel
        send_item(make_item(OP_SYNAPSE, 0, 255, 5000, 0, 1, 1));          // inhibitory source
        send_item(make_item(OP_SYNAPSE, 0, 255, 24'h800000, 1, 1, 1));    // negative weight
        send_item(make_item(OP_SYNAPSE, 0, 255, 24'hFFFFFF, 1, 0, 1));
        send_item(make_item(OP_SYNAPSE, 255, 0, 24'h7FFFFF, 1, 0, 1));    // ceiling
        send_item(make_item(OP_SYNAPSE, 17, 200, 1234, 1, 1, 1));         // empty traces
        send_item(make_item(OP_NEURON, 17, 0, 0, 0, 0, 0));
        drain();
        // floor above ceiling: the floor test wins
        apply_settings(1, 4096, 8192, 65535, 65535, 1, 8388607, 1);
        send_item(make_item(OP_SYNAPSE, 0, 255, 10, 1, 0, 1));
        send_item(make_item(OP_SYNAPSE, 255, 0, 10, 1, 1, 0));
        send_item(make_item(OP_NEURON, 255, 0, 0, 0, 1, 0));
        drain();

        apply_settings(1, 4096, 4301, 62339, 62339, 4096, 0, 819200);
        run_phase(160, 30, 1, 0);
        drain();
        // traces pile up to the ceiling; receiver holds off mid-phase
        apply_settings(1, 65535, 65535, 65535, 65535, 65535, 0, 8388607);
        run_phase(170, 70, 1, 1);
        drain();
        apply_random_settings(1, 0);
        run_phase(160, 40, 1, 0);
        drain();
        apply_random_settings(0, 0);
        run_phase(70, 40, 1, 0);
        drain();
        apply_settings(1, pick_gain(), pick_gain(), 0, 0, $urandom_range(1, 65535), 0, 8388607);
        run_phase(130, 50, 1, 0);
        drain();
        apply_random_settings(1, 1);
        run_phase(130, 40, 1, 0);
        drain();
        apply_random_settings(1, 0);
        run_phase(140, 40, 1, 0);
        drain();
        apply_random_settings(1, 0);
        run_phase(140, 50, 0, 0);
        drain();
        repeat (20) @(negedge clk);

        if (weights_sb.errors == 0 && weights_sb.due_results.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
